@@ sv/ats_pkg.sv @@
// Package for the alarm table scheduler: transaction structs, request codes,
// cell commands, chain link types and controller states.
// No dependencies; every other file imports it.
package ats_pkg;

    localparam int DEPTH_DEF = 16;

    localparam logic signed [31:0] DATA_ANY = -32'sd1;

    typedef enum logic [1:0] {
        REQ_ADD  = 2'd0,
        REQ_DEL  = 2'd1,
        REQ_TICK = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        when_time;
        logic [15:0]        channel_id;
        logic [15:0]        message_id;
        logic signed [31:0] data_value;
        logic               when_any;
        logic               channel_any;
        logic               message_any;
        logic [31:0]        now_time;
    } t_in_item;

    typedef struct packed {
        logic               fired;
        logic [31:0]        fired_when;
        logic [15:0]        fired_channel;
        logic [15:0]        fired_message;
        logic signed [31:0] fired_data;
        logic               status;
        logic [4:0]         pending_count;
        logic               next_valid;
        logic [31:0]        next_when;
    } t_out_item;

    typedef struct packed {
        logic [31:0]        when_time;
        logic [15:0]        channel_id;
        logic [15:0]        message_id;
        logic signed [31:0] data_value;
    } t_alarm;

    typedef struct packed {
        logic   valid;
        t_alarm alarm;
    } t_slot;

    typedef struct packed {
        logic   found;
        t_alarm alarm;
    } t_tok;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_ADD,
        CMD_DEL,
        CMD_FIRE,
        CMD_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_in_item item;
    } t_cell_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COMPACT,
        ST_SCAN
    } t_state;

endpackage

@@ sv/ats_cell.sv @@
// One slot of the alarm row: holds one alarm, closes gaps by taking its right
// neighbour, and passes the running nearest-alarm token to the right.
// Depends on ats_pkg.
module ats_cell
    import ats_pkg::*;
#(
    parameter int IDX = 0,
    parameter int IW  = 4,
    parameter int CW  = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_cmd     i_cmd,
    input  logic [IW-1:0] i_kill_idx,
    input  logic          i_prev_valid,
    input  t_slot         i_next,
    output t_slot         o_slot,
    input  logic          i_hole,
    output logic          o_hole,
    input  logic          i_pend,
    output logic          o_pend,
    input  t_tok          i_tok,
    input  logic [IW-1:0] i_tok_idx,
    input  logic [CW-1:0] i_tok_cnt,
    output t_tok          o_tok,
    output logic [IW-1:0] o_tok_idx,
    output logic [CW-1:0] o_tok_cnt
);

    logic          r_valid, n_valid;
    t_alarm        r_alarm, n_alarm;
    t_tok          r_tok, n_tok;
    logic [IW-1:0] r_tok_idx, n_tok_idx;
    logic [CW-1:0] r_tok_cnt, n_tok_cnt;
    logic          hit;
    logic          take_own;

    assign o_hole = i_hole | ~r_valid;
    assign o_pend = i_pend | (i_hole & r_valid);
    assign o_slot = '{valid: r_valid, alarm: r_alarm};

    assign hit = (i_cmd.item.when_any    || r_alarm.when_time  == i_cmd.item.when_time)
              && (i_cmd.item.channel_any || r_alarm.channel_id == i_cmd.item.channel_id)
              && (i_cmd.item.message_any || r_alarm.message_id == i_cmd.item.message_id)
              && (i_cmd.item.data_value == DATA_ANY
                  || r_alarm.data_value == i_cmd.item.data_value);

    always_comb begin
        n_valid = r_valid;
        n_alarm = r_alarm;
        unique case (i_cmd.op)
            CMD_ADD: begin
                // first empty slot after a full prefix takes the new alarm
                if (!r_valid && i_prev_valid) begin
                    n_valid = 1'b1;
                    n_alarm = '{when_time:  i_cmd.item.when_time,
                                channel_id: i_cmd.item.channel_id,
                                message_id: i_cmd.item.message_id,
                                data_value: i_cmd.item.data_value};
                end
            end
            CMD_DEL: begin
                if (r_valid && hit) begin
                    n_valid = 1'b0;
                end
            end
            CMD_FIRE: begin
                if (i_kill_idx == IW'(IDX)) begin
                    n_valid = 1'b0;
                end
            end
            CMD_SHIFT: begin
                if (o_hole) begin
                    n_valid = i_next.valid;
                    n_alarm = i_next.alarm;
                end
            end
            default: ;
        endcase
    end

    // strictly earlier wins, so the first slot is kept on ties
    assign take_own = r_valid
                   && (!i_tok.found || r_alarm.when_time < i_tok.alarm.when_time);

    always_comb begin
        n_tok_cnt = i_tok_cnt + CW'(r_valid);
        if (take_own) begin
            n_tok     = '{found: 1'b1, alarm: r_alarm};
            n_tok_idx = IW'(IDX);
        end else begin
            n_tok     = i_tok;
            n_tok_idx = i_tok_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok     <= '0;
            r_tok_idx <= '0;
            r_tok_cnt <= '0;
        end else begin
            r_valid   <= n_valid;
            r_tok     <= n_tok;
            r_tok_idx <= n_tok_idx;
            r_tok_cnt <= n_tok_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_alarm <= n_alarm;
    end

    assign o_tok     = r_tok;
    assign o_tok_idx = r_tok_idx;
    assign o_tok_cnt = r_tok_cnt;

endmodule

@@ sv/ats_ctrl.sv @@
// Sequencer of the alarm table: takes a transaction, drives the row of cells
// through execute, compaction and scan, and registers the result.
// Depends on ats_pkg.
module ats_ctrl
    import ats_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IW    = 4,
    parameter int CW    = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_in_item      i_item,
    output logic          o_busy,
    input  logic          i_full,
    input  logic          i_pend,
    input  t_tok          i_tok,
    input  logic [IW-1:0] i_tok_idx,
    input  logic [CW-1:0] i_tok_cnt,
    output t_cell_cmd     o_cmd,
    output logic [IW-1:0] o_kill_idx,
    output logic          o_strobe,
    output t_out_item     o_result
);

    localparam int CWX = (CW > 5) ? CW : 5;

    t_state        r_state, n_state;
    t_in_item      r_item, n_item;
    logic [CW-1:0] r_cnt, n_cnt;
    t_out_item     r_result, n_result;
    logic          r_strobe, n_strobe;
    logic          fire_ok;
    logic [CWX-1:0] cnt_ext;

    assign fire_ok = i_tok.found && (i_tok.alarm.when_time <= r_item.now_time);
    assign cnt_ext = CWX'(i_tok_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_result <= n_result;
    end

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_cnt     = r_cnt;
        n_result  = r_result;
        n_strobe  = 1'b0;
        o_cmd.op   = CMD_HOLD;
        o_cmd.item = r_item;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_item   = i_item;
                    n_result = '0;
                    n_state  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (r_item.req_type)
                    REQ_ADD: begin
                        o_cmd.op        = CMD_ADD;
                        n_result.status = i_full;
                    end
                    REQ_DEL: begin
                        o_cmd.op = CMD_DEL;
                    end
                    REQ_TICK: begin
                        if (fire_ok) begin
                            o_cmd.op               = CMD_FIRE;
                            n_result.fired         = 1'b1;
                            n_result.fired_when    = i_tok.alarm.when_time;
                            n_result.fired_channel = i_tok.alarm.channel_id;
                            n_result.fired_message = i_tok.alarm.message_id;
                            n_result.fired_data    = i_tok.alarm.data_value;
                        end
                    end
                    default: ;
                endcase
                n_state = ST_COMPACT;
            end
            ST_COMPACT: begin
                if (i_pend) begin
                    o_cmd.op = CMD_SHIFT;
                end else begin
                    n_cnt   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cnt == CW'(DEPTH)) begin
                    n_result.pending_count = cnt_ext[4:0];
                    n_result.next_valid    = i_tok.found;
                    n_result.next_when     = i_tok.found ? i_tok.alarm.when_time : '0;
                    n_strobe               = 1'b1;
                    n_state                = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy     = (r_state != ST_IDLE);
    assign o_kill_idx = i_tok_idx;
    assign o_strobe   = r_strobe;
    assign o_result   = r_result;

`ifndef SYNTH
    a_strobe_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == ST_SCAN))
        else $error("result strobe without a finished scan");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !o_busy)
        else $error("result strobe while busy");

    a_shift_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == CMD_SHIFT) |-> (r_state == ST_COMPACT && i_pend))
        else $error("shift issued with no gap to close");

    a_fire_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == CMD_FIRE) |-> (i_tok.found && r_state == ST_EXEC))
        else $error("fire issued without a pending alarm");

    a_fire_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_result.fired && o_result.status))
        else $error("fired and dropped in one result");
`endif

endmodule

@@ sv/alarm_table_scheduler.sv @@
// Alarm table scheduler, top level: a row of DEPTH alarm cells and the
// sequencer that drives it. Depends on ats_pkg, ats_cell and ats_ctrl.
//
// A transaction is taken at a rising edge with start high and busy low; busy
// then stays high until the result has been registered. Each transaction
// gives exactly one result, shown on o_result for one cycle with o_strobe
// high; the receiver cannot stall it, so capture it on that cycle. A
// transaction runs through execute, compaction and scan. Compaction makes
// single-place shifts to close the gaps that a delete or a fired alarm
// leaves behind (at most one for a tick, at most the number of removed
// alarms for a delete, none for an add). The scan is the walk of the
// nearest-alarm token down the row of cells: it moves one cell per cycle
// and gathers the earliest due time and the pending count. There is no
// clearing pass after reset: the valid flags reset at once.
module alarm_table_scheduler
    import ats_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_result
);

    // index width and pending count width follow from the depth
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cell_cmd     cmd;
    logic [IW-1:0] kill_idx;

    // chain links: slots pass leftwards, gap, pending and token rightwards
    t_slot         w_slot      [DEPTH];
    t_slot         w_next      [DEPTH];
    logic          w_prev_valid[DEPTH];
    logic          w_hole      [DEPTH+1];
    logic          w_pend      [DEPTH+1];
    t_tok          w_tok       [DEPTH+1];
    logic [IW-1:0] w_tok_idx   [DEPTH+1];
    logic [CW-1:0] w_tok_cnt   [DEPTH+1];

    // the token enters the row empty, and no gap lies before the first cell
    assign w_hole[0]    = 1'b0;
    assign w_pend[0]    = 1'b0;
    assign w_tok[0]     = '0;
    assign w_tok_idx[0] = '0;
    assign w_tok_cnt[0] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        // the first cell always sits behind a full prefix
        if (g == 0) begin : g_first
            assign w_prev_valid[g] = 1'b1;
        end else begin : g_inner
            assign w_prev_valid[g] = w_slot[g-1].valid;
        end

        // the last cell shifts in an empty slot
        if (g == DEPTH - 1) begin : g_last
            assign w_next[g] = '0;
        end else begin : g_body
            assign w_next[g] = w_slot[g+1];
        end

        ats_cell #(
            .IDX (g),
            .IW  (IW),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_kill_idx   (kill_idx),
            .i_prev_valid (w_prev_valid[g]),
            .i_next       (w_next[g]),
            .o_slot       (w_slot[g]),
            .i_hole       (w_hole[g]),
            .o_hole       (w_hole[g+1]),
            .i_pend       (w_pend[g]),
            .o_pend       (w_pend[g+1]),
            .i_tok        (w_tok[g]),
            .i_tok_idx    (w_tok_idx[g]),
            .i_tok_cnt    (w_tok_cnt[g]),
            .o_tok        (w_tok[g+1]),
            .o_tok_idx    (w_tok_idx[g+1]),
            .o_tok_cnt    (w_tok_cnt[g+1])
        );
    end

    // the table is full when the last cell holds an alarm; the token leaving
    // the last cell carries the nearest alarm and the pending count
    ats_ctrl #(
        .DEPTH (DEPTH),
        .IW    (IW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (i_item),
        .o_busy     (busy),
        .i_full     (w_slot[DEPTH-1].valid),
        .i_pend     (w_pend[DEPTH]),
        .i_tok      (w_tok[DEPTH]),
        .i_tok_idx  (w_tok_idx[DEPTH]),
        .i_tok_cnt  (w_tok_cnt[DEPTH]),
        .o_cmd      (cmd),
        .o_kill_idx (kill_idx),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule
